// File: rtl/core/mfe_pkg.sv
package mfe_pkg;

   localparam int unsigned LEN_W      = 11;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned SEQ_CNT_W  = 3;

   localparam logic [LEN_W-1:0] MAX_FRAME_LEN_RESET = 11'd1536;

   localparam logic                  CSR_IDX_MAX_FRAME_LEN = 1'b0;

   localparam logic [KIND_W-1:0] KIND_LEAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PRE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TRAIL = 2'd3;

   localparam logic [BYTE_W-1:0] PREAMBLE_BYTE  = 8'h55;
   localparam logic [BYTE_W-1:0] DELIMITER_BYTE = 8'hD5;
   localparam logic [WORD_W-1:0] TRAILER_WORD   = 32'hfff00000;

   // Index of the final word of each fixed run.
   localparam logic [SEQ_CNT_W-1:0] LEAD_LAST  = 3'd3;
   localparam logic [SEQ_CNT_W-1:0] PRE_LAST   = 3'd7;
   localparam logic [SEQ_CNT_W-1:0] TRAIL_LAST = 3'd3;

   typedef struct packed {
      logic              has_header;
      logic              has_data;
      logic              has_trailer;
      logic [BYTE_W-1:0] data;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_START,
      ST_LEAD,
      ST_PRE,
      ST_DATA,
      ST_TRAIL
   } seq_state_type;

   function automatic logic [15:0] code_nibble(input logic [3:0] n);
      logic [15:0] r;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         r[15-4*i -: 4] = n[i] ? 4'b0011 : 4'b1100;
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] code_byte(input logic [BYTE_W-1:0] b);
      return {code_nibble(b[3:0]), code_nibble(b[7:4])};
   endfunction

endpackage

// File: rtl/core/manchester_frame_encoder_core.sv
// Channel   Direction  Handshake                 Payload
// req_      in         req_push / req_full       req_data_byte, req_first_byte,
//                                                req_frame_length
// rsp_      out        rsp_empty / rsp_pop       rsp_line_word, rsp_word_kind,
//                                                rsp_last_word
// csr_      in/out     psel, penable, pready     csr_paddr, csr_pwdata, csr_prdata
//
// One input transaction is taken and one line word leaves per cycle at best.
// A data byte yields one data word and the last byte of a frame adds the trailer;
// a frame start adds lead and preamble words. Input stalls only on a full queue.
// The first word of a transaction passes the queue, then the output register.
// Reset is synchronous and clears frame tracking, the queue and the output stage.
// A stalled result holds in the output register while the queue keeps filling.
module manchester_frame_encoder_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [mfe_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic                               req_first_byte,
   input  logic [mfe_pkg::LEN_W-1:0]          req_frame_length,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [mfe_pkg::WORD_W-1:0]         rsp_line_word,
   output logic [mfe_pkg::KIND_W-1:0]         rsp_word_kind,
   output logic                               rsp_last_word,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mfe_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mfe_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mfe_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic [mfe_pkg::LEN_W-1:0] max_frame_len_ff, max_frame_len_in;
   logic                      req_accept;
   logic                      cmd_push;
   mfe_pkg::cmd_type          front_cmd;
   mfe_pkg::cmd_type          head_cmd;
   logic                      cmd_valid;
   logic                      cmd_pop;
   logic                      queue_full;
   logic                      out_valid;
   logic                      rsp_accept;
   logic                      csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[mfe_pkg::CSR_ADDR_W-1] == mfe_pkg::CSR_IDX_MAX_FRAME_LEN);
   assign csr_prdata = csr_hit ? mfe_pkg::CSR_DATA_W'(max_frame_len_ff) : '0;

   always_comb begin
      max_frame_len_in = max_frame_len_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         max_frame_len_in = csr_pwdata[mfe_pkg::LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_len_ff <= mfe_pkg::MAX_FRAME_LEN_RESET;
      end else begin
         max_frame_len_ff <= max_frame_len_in;
      end
   end

   assign req_full   = queue_full;
   assign req_accept = req_push && !queue_full;
   assign rsp_empty  = !out_valid;
   assign rsp_accept = rsp_pop && out_valid;

   mfe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .data_byte     (req_data_byte),
      .first_byte    (req_first_byte),
      .frame_length  (req_frame_length),
      .max_frame_len (max_frame_len_ff),
      .cmd_push      (cmd_push),
      .cmd           (front_cmd)
   );

   mfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (front_cmd),
      .pop      (cmd_pop),
      .head_cmd (head_cmd),
      .nonempty (cmd_valid),
      .full     (queue_full)
   );

   mfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .out_valid (out_valid),
      .out_pop   (rsp_accept),
      .line_word (rsp_line_word),
      .word_kind (rsp_word_kind),
      .last_word (rsp_last_word)
   );

endmodule

// File: rtl/core/mfe_front.sv
module mfe_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [mfe_pkg::BYTE_W-1:0]   data_byte,
   input  logic                         first_byte,
   input  logic [mfe_pkg::LEN_W-1:0]    frame_length,
   input  logic [mfe_pkg::LEN_W-1:0]    max_frame_len,
   output logic                         cmd_push,
   output mfe_pkg::cmd_type             cmd
);

   logic [mfe_pkg::LEN_W-1:0] bytes_left_ff, bytes_left_in;
   logic                      dropping_ff, dropping_in;
   logic [mfe_pkg::LEN_W-1:0] left_dec;

   assign left_dec = bytes_left_ff - 1'b1;

   always_comb begin
      bytes_left_in   = bytes_left_ff;
      dropping_in     = dropping_ff;
      cmd_push        = 1'b0;
      cmd.has_header  = 1'b0;
      cmd.has_data    = 1'b0;
      cmd.has_trailer = 1'b0;
      cmd.data        = data_byte;
      if (accept) begin
         if (first_byte) begin
            // A new frame abandons whatever frame was in progress.
            if (frame_length > max_frame_len) begin
               dropping_in   = 1'b1;
               bytes_left_in = frame_length - 1'b1;
            end else begin
               dropping_in    = 1'b0;
               cmd_push       = 1'b1;
               cmd.has_header = 1'b1;
               if (frame_length == '0) begin
                  bytes_left_in   = '0;
                  cmd.has_trailer = 1'b1;
               end else begin
                  bytes_left_in   = frame_length - 1'b1;
                  cmd.has_data    = 1'b1;
                  cmd.has_trailer = (frame_length == mfe_pkg::LEN_W'(1));
               end
            end
         end else if (bytes_left_ff != '0) begin
            bytes_left_in = left_dec;
            if (dropping_ff) begin
               if (left_dec == '0) begin
                  dropping_in = 1'b0;
               end
            end else begin
               cmd_push        = 1'b1;
               cmd.has_data    = 1'b1;
               cmd.has_trailer = (left_dec == '0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         dropping_ff   <= 1'b0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         dropping_ff   <= dropping_in;
      end
   end

endmodule

// File: rtl/core/mfe_queue.sv
module mfe_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mfe_pkg::cmd_type push_cmd,
   input  logic             pop,
   output mfe_pkg::cmd_type head_cmd,
   output logic             nonempty,
   output logic             full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   mfe_pkg::cmd_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign head_cmd = slot_ff[rd_ptr_ff];
   assign nonempty = (count_ff != '0);
   assign full     = (count_ff == CNT_FULL);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/core/mfe_back.sv
module mfe_back (
   input  logic                         clock,
   input  logic                         reset,
   input  mfe_pkg::cmd_type             head_cmd,
   input  logic                         cmd_valid,
   output logic                         cmd_pop,
   output logic                         out_valid,
   input  logic                         out_pop,
   output logic [mfe_pkg::WORD_W-1:0]   line_word,
   output logic [mfe_pkg::KIND_W-1:0]   word_kind,
   output logic                         last_word
);

   mfe_pkg::seq_state_type           state_ff, state_in, cur_state;
   logic [mfe_pkg::SEQ_CNT_W-1:0]    cnt_ff, cnt_in, cur_cnt;
   logic                             out_valid_ff, out_valid_in;
   logic [mfe_pkg::WORD_W-1:0]       word_ff, word_nx;
   logic [mfe_pkg::KIND_W-1:0]       kind_ff, kind_nx;
   logic                             last_ff, last_nx;
   logic                             advance;

   assign advance   = cmd_valid && (!out_valid_ff || out_pop);
   assign cmd_pop   = advance && last_nx;
   assign out_valid = out_valid_ff;
   assign line_word = word_ff;
   assign word_kind = kind_ff;
   assign last_word = last_ff;

   // At the start of a transaction the first phase follows from the command itself,
   // so a new command emits its first word without a dead cycle.
   always_comb begin
      cur_cnt = cnt_ff;
      if (state_ff == mfe_pkg::ST_START) begin
         cur_cnt = '0;
         if (head_cmd.has_header) begin
            cur_state = mfe_pkg::ST_LEAD;
         end else if (head_cmd.has_data) begin
            cur_state = mfe_pkg::ST_DATA;
         end else begin
            cur_state = mfe_pkg::ST_TRAIL;
         end
      end else begin
         cur_state = state_ff;
      end
   end

   // Word produced in the current phase.
   always_comb begin
      word_nx = '0;
      kind_nx = mfe_pkg::KIND_LEAD;
      last_nx = 1'b0;
      case (cur_state)
         mfe_pkg::ST_LEAD: begin
            word_nx = '0;
            kind_nx = mfe_pkg::KIND_LEAD;
         end
         mfe_pkg::ST_PRE: begin
            word_nx = (cur_cnt == mfe_pkg::PRE_LAST) ?
                      mfe_pkg::code_byte(mfe_pkg::DELIMITER_BYTE) :
                      mfe_pkg::code_byte(mfe_pkg::PREAMBLE_BYTE);
            kind_nx = mfe_pkg::KIND_PRE;
         end
         mfe_pkg::ST_DATA: begin
            word_nx = mfe_pkg::code_byte(head_cmd.data);
            kind_nx = mfe_pkg::KIND_DATA;
            last_nx = !head_cmd.has_trailer;
         end
         mfe_pkg::ST_TRAIL: begin
            word_nx = (cur_cnt == '0) ? mfe_pkg::TRAILER_WORD : '0;
            kind_nx = mfe_pkg::KIND_TRAIL;
            last_nx = (cur_cnt == mfe_pkg::TRAIL_LAST);
         end
         default: begin
            word_nx = '0;
            kind_nx = mfe_pkg::KIND_LEAD;
            last_nx = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      if (advance) begin
         if (last_nx) begin
            state_in = mfe_pkg::ST_START;
            cnt_in   = '0;
         end else begin
            case (cur_state)
               mfe_pkg::ST_LEAD: begin
                  if (cur_cnt == mfe_pkg::LEAD_LAST) begin
                     state_in = mfe_pkg::ST_PRE;
                     cnt_in   = '0;
                  end else begin
                     state_in = mfe_pkg::ST_LEAD;
                     cnt_in   = cur_cnt + 1'b1;
                  end
               end
               mfe_pkg::ST_PRE: begin
                  if (cur_cnt == mfe_pkg::PRE_LAST) begin
                     state_in = head_cmd.has_data ? mfe_pkg::ST_DATA : mfe_pkg::ST_TRAIL;
                     cnt_in   = '0;
                  end else begin
                     state_in = mfe_pkg::ST_PRE;
                     cnt_in   = cur_cnt + 1'b1;
                  end
               end
               mfe_pkg::ST_DATA: begin
                  state_in = mfe_pkg::ST_TRAIL;
                  cnt_in   = '0;
               end
               mfe_pkg::ST_TRAIL: begin
                  state_in = mfe_pkg::ST_TRAIL;
                  cnt_in   = cur_cnt + 1'b1;
               end
               default: begin
                  state_in = mfe_pkg::ST_START;
                  cnt_in   = '0;
               end
            endcase
         end
      end
   end

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfe_pkg::ST_START;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_nx;
         kind_ff <= kind_nx;
         last_ff <= last_nx;
      end
   end

endmodule
